// ----- hw/rtl/tkrs_pkg.sv -----
`default_nettype none

package tkrs_pkg;

  localparam int unsigned KEY_W            = 50;
  localparam int unsigned ORD_W            = 6;
  localparam int unsigned MAX_RECORDS_DEF  = 32;
  localparam int unsigned SCORE_BITS_DEF   = 16;

endpackage

`default_nettype wire

// ----- hw/rtl/tkrs_ram.sv -----
`default_nettype none

module tkrs_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/two_key_record_sorter.sv -----
// after the final transfer each pass scans the stored records and then emits one ordinal,
// one pass per stored record, so a batch of n stored records yields n ordinals
// each pass reads every stored record once through the single read port of the record ram
// idle transfers store the records; busy stays high from the final transfer to the last ordinal
// the receiver cannot stall: each ordinal is shown for one cycle under valid_o
// reset clears the record count, drop flag and pick marks; ram contents are not cleared
`default_nettype none

module two_key_record_sorter
  import tkrs_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int unsigned SCORE_BITS  = SCORE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [KEY_W-1:0]      name_key_i,
  input  wire logic [SCORE_BITS-1:0] score_i,
  input  wire logic                  final_record_i,
  output logic                       valid_o,
  output logic [ORD_W-1:0]           ordinal_o,
  output logic                       last_result_o,
  output logic                       overflowed_o
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned DW = KEY_W + SCORE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           cnt_q;
  logic [CW-1:0]           emit_q;
  logic                    drop_q;
  logic [MAX_RECORDS-1:0]  used_q;
  logic [AW-1:0]           addr_q;
  logic                    pend_q;
  logic [AW-1:0]           pend_idx_q;
  logic                    best_vld_q;
  logic [KEY_W-1:0]        best_key_q;
  logic [SCORE_BITS-1:0]   best_score_q;
  logic [AW-1:0]           best_idx_q;

  logic [KEY_W-1:0]        best_key_d;
  logic [SCORE_BITS-1:0]   best_score_d;
  logic [AW-1:0]           best_idx_d;
  logic [IW-1:0]           ord_sum;

  logic                    xfer;
  logic                    ram_we;
  logic [DW-1:0]           ram_rdata;
  logic [KEY_W-1:0]        rd_key;
  logic [SCORE_BITS-1:0]   rd_score;
  logic                    take;
  logic                    scan_end;
  logic                    pass_last;

  assign busy   = (state_q != ST_IDLE);
  assign xfer   = start && !busy;
  assign ram_we = xfer && (cnt_q < CW'(MAX_RECORDS));

  tkrs_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({name_key_i, score_i}),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_key   = ram_rdata[DW-1:SCORE_BITS];
  assign rd_score = ram_rdata[SCORE_BITS-1:0];

  always_comb begin
    take = pend_q && !used_q[pend_idx_q] &&
           (!best_vld_q || (rd_key < best_key_q) ||
            ((rd_key == best_key_q) && (rd_score > best_score_q)));
    best_key_d   = take ? rd_key     : best_key_q;
    best_score_d = take ? rd_score   : best_score_q;
    best_idx_d   = take ? pend_idx_q : best_idx_q;
    ord_sum      = {1'b0, best_idx_d} + IW'(1);
    scan_end     = ((CW'(addr_q) + CW'(1)) == cnt_q);
    pass_last    = ((emit_q + CW'(1)) == cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      emit_q        <= '0;
      drop_q        <= 1'b0;
      used_q        <= '0;
      addr_q        <= '0;
      pend_q        <= 1'b0;
      pend_idx_q    <= '0;
      best_vld_q    <= 1'b0;
      best_key_q    <= '0;
      best_score_q  <= '0;
      best_idx_q    <= '0;
      valid_o       <= 1'b0;
      ordinal_o     <= '0;
      last_result_o <= 1'b0;
      overflowed_o  <= 1'b0;
    end else begin
      valid_o      <= 1'b0;
      pend_q       <= (state_q == ST_SCAN);
      pend_idx_q   <= addr_q;
      best_key_q   <= best_key_d;
      best_score_q <= best_score_d;
      best_idx_q   <= best_idx_d;
      if (take) begin
        best_vld_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (xfer) begin
            if (ram_we) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (final_record_i) begin
              state_q    <= ST_SCAN;
              addr_q     <= '0;
              emit_q     <= '0;
              best_vld_q <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          valid_o       <= 1'b1;
          ordinal_o     <= ORD_W'(ord_sum);
          last_result_o <= pass_last;
          overflowed_o  <= drop_q;
          addr_q        <= '0;
          best_vld_q    <= 1'b0;
          if (pass_last) begin
            state_q <= ST_IDLE;
            cnt_q   <= '0;
            drop_q  <= 1'b0;
            used_q  <= '0;
            emit_q  <= '0;
          end else begin
            state_q            <= ST_SCAN;
            used_q[best_idx_d] <= 1'b1;
            emit_q             <= emit_q + CW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RECORDS))
    else $error("record count above capacity");

  a_drain_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> pend_q)
    else $error("drain without a pending read");

  a_no_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("results in adjacent cycles");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_result_o) |-> busy)
    else $error("idle before batch end");

  a_batch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_result_o) |-> ((cnt_q == '0) && !drop_q && (used_q == '0)))
    else $error("batch state not cleared");
`endif

endmodule

`default_nettype wire
